// ----- sv/tsf_pkg.sv -----
// Shared types and control byte codes for the terminal sequence filter.
`default_nettype none

package tsf_pkg;

    // Control byte codes of the terminal data stream
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_SI  = 8'h0F;
    localparam logic [7:0] CH_SOE = 8'h1E;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_EM  = 8'h19;
    localparam logic [7:0] CH_US  = 8'h1F;
    localparam logic [7:0] CH_SO  = 8'h0E;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_HT  = 8'h09;
    localparam logic [7:0] CH_FS  = 8'h1C;
    localparam logic [7:0] CH_DC3 = 8'h13;
    localparam logic [7:0] CH_X   = 8'h58;
    localparam logic [7:0] CH_Y   = 8'h59;
    localparam logic [7:0] CH_Z   = 8'h5A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;

    // Pending lead byte class
    typedef enum logic [1:0] {
        LEAD_NONE = 2'd0,
        LEAD_ESC  = 2'd1,
        LEAD_FCC  = 2'd2,
        LEAD_SO   = 2'd3
    } t_lead;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_end;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/terminal_sequence_filter.sv -----
// Top level of the terminal sequence filter: byte classifier, skip counter, output skid.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_in_byte, i_message_end
//   result    out        o_valid / i_stall    o_out_byte, o_out_valid, o_out_end
//
// One item per cycle while o_stall is low; each accepted byte yields one registered result item.
// The lead register and the 3-bit skip counter update in the same cycle as the byte.
// Reset is synchronous, active low, and clears the lead, the counter and both output slots.
// A stalled result is held in the output register; one more item is caught in the skid
// register, and o_stall rises only while that skid slot is full.
`default_nettype none

module terminal_sequence_filter (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire  [7:0] i_in_byte,
    input  wire        i_message_end,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic       o_out_end
);

    tsf_pkg::t_lead   r_lead, n_lead;
    logic [2:0]       r_skip, n_skip;
    tsf_pkg::t_result r_out, r_skid, n_res;
    logic             r_out_vld, r_skid_vld;
    logic             accept, out_free;

    // Bytes still to drop after the selector, given the lead class
    function automatic logic [2:0] skip_after(tsf_pkg::t_lead kind, logic [7:0] sel);
        logic [2:0] len;
        len = 3'd0;
        unique case (kind)
            tsf_pkg::LEAD_ESC: begin
                if (sel == tsf_pkg::CH_VT) len = 3'd3;
                else if (sel == tsf_pkg::CH_FS || sel == tsf_pkg::CH_X ||
                         sel == tsf_pkg::CH_Y || sel == tsf_pkg::CH_Z) len = 3'd1;
                else len = 3'd0;
            end
            tsf_pkg::LEAD_FCC: begin
                if (sel == tsf_pkg::CH_SP || sel == tsf_pkg::CH_BANG ||
                    sel == tsf_pkg::CH_QUOTE) len = 3'd3;
                else if (sel == tsf_pkg::CH_HASH) len = 3'd4;
                else len = 3'd1;
            end
            tsf_pkg::LEAD_SO: begin
                if (sel == tsf_pkg::CH_DC3) len = 3'd1;
                else len = 3'd3;
            end
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    assign accept   = i_valid && !r_skid_vld;
    assign out_free = !r_out_vld || !i_stall;

    // Classify the incoming byte and work out the next lead and skip state
    always_comb begin
        logic keep;
        keep   = 1'b0;
        n_lead = r_lead;
        n_skip = r_skip;
        if (r_skip != 3'd0) begin
            n_skip = r_skip - 3'd1;
        end else if (r_lead != tsf_pkg::LEAD_NONE) begin
            n_skip = skip_after(r_lead, i_in_byte);
            n_lead = tsf_pkg::LEAD_NONE;
        end else if (i_in_byte == tsf_pkg::CH_NUL || i_in_byte == tsf_pkg::CH_SI ||
                     i_in_byte == tsf_pkg::CH_SOE) begin
            n_skip = 3'd1;
        end else if (i_in_byte == tsf_pkg::CH_ESC) begin
            n_lead = tsf_pkg::LEAD_ESC;
        end else if (i_in_byte == tsf_pkg::CH_EM || i_in_byte == tsf_pkg::CH_US) begin
            n_lead = tsf_pkg::LEAD_FCC;
        end else if (i_in_byte == tsf_pkg::CH_SO) begin
            n_lead = tsf_pkg::LEAD_SO;
        end else begin
            keep = 1'b1;
        end
        // Drop any open sequence at message end
        if (i_message_end) begin
            n_lead = tsf_pkg::LEAD_NONE;
            n_skip = 3'd0;
        end
        n_res.out_byte  = keep ? i_in_byte : 8'h00;
        n_res.out_valid = keep;
        n_res.out_end   = i_message_end;
    end

    // Advance the sequence state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= tsf_pkg::LEAD_NONE;
            r_skip <= 3'd0;
        end else if (accept) begin
            r_lead <= n_lead;
            r_skip <= n_skip;
        end
    end

    // Output register with skid slot behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= accept;
            end
        end else if (accept) begin
            r_skid_vld <= 1'b1;
        end
    end

    // Payload moves without reset
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_vld) r_out <= r_skid;
            else if (accept) r_out <= n_res;
        end else if (accept) begin
            r_skid <= n_res;
        end
    end

    assign o_stall     = r_skid_vld;
    assign o_valid     = r_out_vld;
    assign o_out_byte  = r_out.out_byte;
    assign o_out_valid = r_out.out_valid;
    assign o_out_end   = r_out.out_end;

endmodule

`default_nettype wire

// ----- sv/tsf_checker.sv -----
// Port-level checker for the terminal sequence filter and its bind.
`default_nettype none

module tsf_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       o_stall,
    input wire [7:0] i_in_byte,
    input wire       i_message_end,
    input wire       o_valid,
    input wire       i_stall,
    input wire [7:0] o_out_byte,
    input wire       o_out_valid,
    input wire       o_out_end
);

    // A dropped byte shows as zero
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_valid) |-> (o_out_byte == 8'h00))
        else $error("dropped item carries a nonzero byte");

    // Lead and drop-pair codes never pass as kept text
    a_no_ctrl_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_valid) |->
        (o_out_byte != tsf_pkg::CH_ESC && o_out_byte != tsf_pkg::CH_EM &&
         o_out_byte != tsf_pkg::CH_US && o_out_byte != tsf_pkg::CH_SO &&
         o_out_byte != tsf_pkg::CH_NUL && o_out_byte != tsf_pkg::CH_SI &&
         o_out_byte != tsf_pkg::CH_SOE))
        else $error("control byte passed as kept text");

    // Input stall only follows a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stalled without a stalled result");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
        (o_valid && $stable(o_out_byte) && $stable(o_out_valid) && $stable(o_out_end)))
        else $error("stalled result changed");

endmodule

bind terminal_sequence_filter tsf_checker u_tsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_in_byte     (i_in_byte),
    .i_message_end (i_message_end),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_out_byte    (o_out_byte),
    .o_out_valid   (o_out_valid),
    .o_out_end     (o_out_end)
);

`default_nettype wire

// ----- bench/terminal_sequence_filter_test.sv -----
// Self-checking bench for the terminal sequence filter: scripted and random byte streams.
`timescale 1ns / 100ps

module terminal_sequence_filter_test;

    localparam int RANDOM_ITEMS = 1050;
    localparam int HOLD_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PERCENT = 18;

    // Tracks filter state and holds the result items still owed by the block
    class filter_scoreboard;
        tsf_pkg::t_lead   lead;
        logic [2:0]       skip;
        tsf_pkg::t_result owed_q[$];
        int               errors;

        function new();
            lead   = tsf_pkg::LEAD_NONE;
            skip   = 3'd0;
            errors = 0;
        endfunction

        // Total sequence length picked by the byte after a lead
        function int unsigned span(tsf_pkg::t_lead kind, logic [7:0] sel);
            case (kind)
                tsf_pkg::LEAD_ESC: begin
                    if (sel == tsf_pkg::CH_VT) return 5;
                    if (sel == tsf_pkg::CH_FS || sel == tsf_pkg::CH_X ||
                        sel == tsf_pkg::CH_Y || sel == tsf_pkg::CH_Z) return 3;
                    return 2;
                end
                tsf_pkg::LEAD_FCC: begin
                    if (sel == tsf_pkg::CH_SP || sel == tsf_pkg::CH_BANG ||
                        sel == tsf_pkg::CH_QUOTE) return 5;
                    if (sel == tsf_pkg::CH_HASH) return 6;
                    return 3;
                end
                default: begin
                    if (sel == tsf_pkg::CH_DC3) return 3;
                    return 5;
                end
            endcase
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        // Advance the filter state by one accepted item and queue its result
        task note_input(logic [7:0] b, logic last);
            tsf_pkg::t_result r;
            logic             keep;
            keep = 1'b0;
            if (skip != 3'd0) begin
                skip = skip - 3'd1;
            end else if (lead != tsf_pkg::LEAD_NONE) begin
                skip = 3'(span(lead, b) - 2);
                lead = tsf_pkg::LEAD_NONE;
            end else if (b == tsf_pkg::CH_NUL || b == tsf_pkg::CH_SI ||
                         b == tsf_pkg::CH_SOE) begin
                skip = 3'd1;
            end else if (b == tsf_pkg::CH_ESC) begin
                lead = tsf_pkg::LEAD_ESC;
            end else if (b == tsf_pkg::CH_EM || b == tsf_pkg::CH_US) begin
                lead = tsf_pkg::LEAD_FCC;
            end else if (b == tsf_pkg::CH_SO) begin
                lead = tsf_pkg::LEAD_SO;
            end else begin
                keep = 1'b1;
            end
            // Message end cuts off whatever sequence is open
            if (last) begin
                lead = tsf_pkg::LEAD_NONE;
                skip = 3'd0;
            end
            r.out_byte  = keep ? b : 8'h00;
            r.out_valid = keep;
            r.out_end   = last;
            owed_q.push_back(r);
        endtask

        // Compare one accepted result item with the oldest owed one
        task check_result(logic [7:0] b, logic v, logic last);
            tsf_pkg::t_result r;
            if (owed_q.size() == 0) begin
                report($sformatf("result %02h/%0b/%0b with nothing owed", b, v, last));
                return;
            end
            r = owed_q.pop_front();
            if (b !== r.out_byte)
                report($sformatf("out_byte %02h, want %02h", b, r.out_byte));
            if (v !== r.out_valid)
                report($sformatf("out_valid %0b, want %0b", v, r.out_valid));
            if (last !== r.out_end)
                report($sformatf("out_end %0b, want %0b", last, r.out_end));
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_in_byte;
    logic       i_message_end;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_out_valid;
    logic       o_out_end;

    filter_scoreboard sb = new();
    bit  calm     = 1'b0;
    bit  hold_req = 1'b0;
    int  sent_random = 0;
    int  cycle_count = 0;

    terminal_sequence_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .i_message_end (i_message_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_out_valid   (o_out_valid),
        .o_out_end     (o_out_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Watch both handshakes on pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_result(o_out_byte, o_out_valid, o_out_end);
            if (i_valid && !o_stall)
                sb.note_input(i_in_byte, i_message_end);
        end
    end

    // Receiver: random stalls, or one long hold when asked
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    // Offer one item, with an optional idle gap first; return once accepted
    task automatic send_item(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if (!calm)
            while (gap < 8 && $urandom_range(99) < IDLE_PERCENT) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_in_byte     <= b;
        i_message_end <= last;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic logic [7:0] text_byte();
        case ($urandom_range(2))
            0:       return 8'($urandom_range(8'h20, 8'h7E));
            1:       return 8'($urandom_range(8'h80, 8'hFF));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Build one message of text and control sequences, then send it
    task automatic send_message();
        logic [7:0]     msg[$];
        logic [7:0]     sel;
        tsf_pkg::t_lead kind;
        int             pieces;
        int             cut;
        if ($urandom_range(9) == 0) begin
            // noise: arbitrary bytes
            repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(0, 255)));
        end else begin
            pieces = $urandom_range(1, 8);
            repeat (pieces) begin
                kind = tsf_pkg::LEAD_NONE;
                case ($urandom_range(9))
                    5: begin
                        case ($urandom_range(2))
                            0:       msg.push_back(tsf_pkg::CH_NUL);
                            1:       msg.push_back(tsf_pkg::CH_SI);
                            default: msg.push_back(tsf_pkg::CH_SOE);
                        endcase
                        msg.push_back(8'($urandom_range(0, 255)));
                    end
                    6: begin
                        kind = tsf_pkg::LEAD_ESC;
                        msg.push_back(tsf_pkg::CH_ESC);
                        case ($urandom_range(6))
                            0:       sel = tsf_pkg::CH_VT;
                            1:       sel = tsf_pkg::CH_FS;
                            2:       sel = tsf_pkg::CH_X;
                            3:       sel = tsf_pkg::CH_Y;
                            4:       sel = tsf_pkg::CH_Z;
                            5:       sel = tsf_pkg::CH_HT;
                            default: sel = 8'($urandom_range(0, 255));
                        endcase
                    end
                    7: begin
                        kind = tsf_pkg::LEAD_FCC;
                        msg.push_back($urandom_range(1) ? tsf_pkg::CH_EM : tsf_pkg::CH_US);
                        case ($urandom_range(4))
                            0:       sel = tsf_pkg::CH_SP;
                            1:       sel = tsf_pkg::CH_BANG;
                            2:       sel = tsf_pkg::CH_QUOTE;
                            3:       sel = tsf_pkg::CH_HASH;
                            default: sel = 8'($urandom_range(0, 255));
                        endcase
                    end
                    8: begin
                        kind = tsf_pkg::LEAD_SO;
                        msg.push_back(tsf_pkg::CH_SO);
                        sel = $urandom_range(1) ? tsf_pkg::CH_DC3 : 8'($urandom_range(0, 255));
                    end
                    default: msg.push_back(text_byte());
                endcase
                // selector plus the rest of the sequence
                if (kind != tsf_pkg::LEAD_NONE) begin
                    msg.push_back(sel);
                    repeat (sb.span(kind, sel) - 2) msg.push_back(8'($urandom_range(0, 255)));
                end
            end
            // now and then cut the message short inside a sequence
            if (msg.size() > 1 && $urandom_range(4) == 0) begin
                cut = $urandom_range(1, msg.size() - 1);
                while (msg.size() > cut) void'(msg.pop_back());
            end
        end
        foreach (msg[i]) begin
            send_item(msg[i], i == msg.size() - 1);
            sent_random++;
        end
    endtask

    // Scripted items as {message_end, byte}
    logic [8:0] script[25] = '{
        {1'b0, 8'hFF},            {1'b0, tsf_pkg::CH_NUL},
        {1'b0, tsf_pkg::CH_ESC},  {1'b0, tsf_pkg::CH_ESC},
        {1'b0, tsf_pkg::CH_SO},   {1'b0, tsf_pkg::CH_SP},
        {1'b0, tsf_pkg::CH_EM},   {1'b0, tsf_pkg::CH_HASH},
        {1'b0, tsf_pkg::CH_NUL},  {1'b0, tsf_pkg::CH_SI},
        {1'b0, tsf_pkg::CH_SOE},  {1'b0, tsf_pkg::CH_US},
        {1'b0, 8'h7F},            {1'b0, tsf_pkg::CH_SO},
        {1'b0, tsf_pkg::CH_DC3},  {1'b0, 8'h41},
        {1'b1, tsf_pkg::CH_ESC},  {1'b0, tsf_pkg::CH_VT},
        {1'b0, tsf_pkg::CH_US},   {1'b0, tsf_pkg::CH_QUOTE},
        {1'b1, 8'h30},            {1'b0, 8'h31},
        {1'b1, tsf_pkg::CH_SOE},  {1'b1, tsf_pkg::CH_NUL},
        {1'b1, 8'h80}
    };

    initial begin
        bit held;
        bit paused;
        held          = 1'b0;
        paused        = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_in_byte     = 8'h00;
        i_message_end = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Scripted part: extremes and several lead, selector, drop-pair and message-end cases
        foreach (script[k]) send_item(script[k][7:0], script[k][8]);

        // Random messages, with a long receiver hold, a calm stretch and a drain pause
        while (sent_random < RANDOM_ITEMS) begin
            if (!held && sent_random >= 350) begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            calm = (sent_random >= 550 && sent_random < 750);
            if (!paused && sent_random >= 880) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                do @(posedge i_clk); while (sb.pending() != 0);
            end
            send_message();
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        // Drain, then give stray results a chance to show
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
